// ===== rtl/core/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame packet reassembler package
// Shared constants, status and fault codes, and the result item type.
// ----------------------------------------------------------------------------
package fpr_pkg;

   localparam int PACKET_CAPACITY  = 255;
   localparam int FRAME_BYTES      = 20;
   localparam int HEADER_BYTES     = 4;
   localparam int FIRST_CONT_ADDR  = 16;
   localparam int CONT_PAYLOAD     = 19;
   localparam int POS_MAX          = 31;
   localparam int MAX_FRAME_RESET  = 13;

   typedef enum logic [1:0] {
      ST_COMPLETE   = 2'd0,
      ST_INCOMPLETE = 2'd1,
      ST_FRAME_ERR  = 2'd2,
      ST_HEADER_ERR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_FRAME  = 2'd2,
      FAULT_HEADER = 2'd3
   } fault_type;

   typedef struct packed {
      logic       write_enable;
      logic [7:0] write_address;
      logic [7:0] write_value;
      logic       status_valid;
      status_type status_code;
      logic [14:0] packet_index;
      logic [7:0] received_length;
   } rsp_type;

endpackage

// ===== rtl/core/frame_packet_reassembler.sv =====
// ----------------------------------------------------------------------------
// Frame packet reassembler
// Rebuilds a packet from link frame bytes: at most one buffer write request and,
// on a frame's last byte, one status per item.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered before it is offered.
// Throughput: one item per cycle while req_ready is high; the per-byte
// update is a single pass of compares, one small constant multiply and adds
// into a registered result. A two-entry result buffer keeps req_ready high
// while one result waits. Reset (synchronous) clears all receive state,
// empties the result buffer and sets max_frame_number to 13.
module frame_packet_reassembler (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_frame_byte,
   input  logic                    req_first_of_frame,
   input  logic                    req_last_of_frame,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_write_enable,
   output logic [7:0]              rsp_write_address,
   output logic [7:0]              rsp_write_value,
   output logic                    rsp_status_valid,
   output logic [1:0]              rsp_status_code,
   output logic [14:0]             rsp_packet_index,
   output logic [7:0]              rsp_received_length,
   input  logic                    csr_write_enable,
   input  logic [3:0]              csr_write_data
);
   import fpr_pkg::*;

   logic        receiving_ff, receiving_in;
   logic [14:0] current_index_ff, current_index_in;
   logic [7:0]  expected_length_ff, expected_length_in;
   logic [7:0]  accepted_length_ff, accepted_length_in;
   logic [3:0]  frame_number_ff, frame_number_in;
   logic [4:0]  byte_position_ff, byte_position_in;
   fault_type   frame_fault_ff, frame_fault_in;
   logic [3:0]  max_frame_number_ff;

   rsp_type     result;
   rsp_type     out_ff, out_in;
   rsp_type     skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic        accept;
   logic        take_out;
   logic [4:0]  pos;
   fault_type   fault;
   logic        payload;
   logic [9:0]  addr;
   logic [3:0]  fn_m1;
   status_type  code;

   assign accept   = req_valid && req_ready;
   assign take_out = out_valid_ff && rsp_ready;
   assign fn_m1    = frame_number_ff - 4'd1;

   always_comb begin
      receiving_in       = receiving_ff;
      current_index_in   = current_index_ff;
      expected_length_in = expected_length_ff;
      accepted_length_in = accepted_length_ff;
      frame_number_in    = frame_number_ff;
      payload            = 1'b0;
      addr               = '0;
      code               = ST_COMPLETE;
      result             = '0;

      pos   = req_first_of_frame ? 5'd0 : byte_position_ff;
      fault = (pos == 5'd0) ? FAULT_NONE : frame_fault_ff;
      frame_fault_in = fault;

      if (pos < 5'(FRAME_BYTES) && fault == FAULT_NONE) begin
         if (!receiving_ff) begin
            if (pos == 5'd0) begin
               if (!req_frame_byte[7]) begin
                  frame_fault_in = FAULT_HEADER;
               end else begin
                  current_index_in   = {req_frame_byte[6:0], 8'h00};
                  accepted_length_in = '0;
                  expected_length_in = '0;
               end
            end else if (pos == 5'd1) begin
               current_index_in = {current_index_ff[14:8], req_frame_byte};
            end else if (pos == 5'd2) begin
               expected_length_in = ({1'b0, req_frame_byte} > 9'(PACKET_CAPACITY))
                                    ? 8'(PACKET_CAPACITY) : req_frame_byte;
            end else if (pos >= 5'(HEADER_BYTES)) begin
               payload = 1'b1;
               addr    = 10'(pos) - 10'(HEADER_BYTES);
            end
         end else begin
            if (pos == 5'd0) begin
               frame_number_in = req_frame_byte[3:0];
               if (req_frame_byte == 8'd0 || req_frame_byte > {4'h0, max_frame_number_ff})
                  frame_fault_in = FAULT_FRAME;
            end else begin
               payload = 1'b1;
               addr    = 10'(FIRST_CONT_ADDR) + 10'(fn_m1) * 10'(CONT_PAYLOAD)
                         + 10'(pos - 5'd1);
            end
         end
      end

      if (payload && accepted_length_ff < expected_length_ff) begin
         accepted_length_in = accepted_length_ff + 8'd1;
         if (addr < 10'(PACKET_CAPACITY)) begin
            result.write_enable  = 1'b1;
            result.write_address = addr[7:0];
            result.write_value   = req_frame_byte;
         end
      end

      if (req_last_of_frame) begin
         if (frame_fault_in == FAULT_HEADER || (!receiving_ff && pos < 5'd3)) begin
            code         = ST_HEADER_ERR;
            receiving_in = 1'b0;
         end else if (frame_fault_in == FAULT_FRAME) begin
            code               = ST_FRAME_ERR;
            receiving_in       = 1'b0;
            accepted_length_in = '0;
            expected_length_in = '0;
         end else if (accepted_length_in < expected_length_in) begin
            code         = ST_INCOMPLETE;
            receiving_in = 1'b1;
         end else begin
            code         = ST_COMPLETE;
            receiving_in = 1'b0;
         end
         result.status_valid = 1'b1;
         result.status_code  = code;
         byte_position_in    = '0;
         frame_fault_in      = FAULT_NONE;
      end else begin
         byte_position_in = (pos < 5'(POS_MAX)) ? pos + 5'd1 : pos;
      end

      result.packet_index    = current_index_in;
      result.received_length = accepted_length_in;
   end

   // two-entry result buffer: head drives the ports, skid catches a stalled item
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff        <= 1'b0;
         current_index_ff    <= '0;
         expected_length_ff  <= '0;
         accepted_length_ff  <= '0;
         frame_number_ff     <= '0;
         byte_position_ff    <= '0;
         frame_fault_ff      <= FAULT_NONE;
         max_frame_number_ff <= 4'(MAX_FRAME_RESET);
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            receiving_ff       <= receiving_in;
            current_index_ff   <= current_index_in;
            expected_length_ff <= expected_length_in;
            accepted_length_ff <= accepted_length_in;
            frame_number_ff    <= frame_number_in;
            byte_position_ff   <= byte_position_in;
            frame_fault_ff     <= frame_fault_in;
         end
         if (csr_write_enable)
            max_frame_number_ff <= csr_write_data;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ready           = !skid_valid_ff;
   assign rsp_valid           = out_valid_ff;
   assign rsp_write_enable    = out_ff.write_enable;
   assign rsp_write_address   = out_ff.write_address;
   assign rsp_write_value     = out_ff.write_value;
   assign rsp_status_valid    = out_ff.status_valid;
   assign rsp_status_code     = out_ff.status_code;
   assign rsp_packet_index    = out_ff.packet_index;
   assign rsp_received_length = out_ff.received_length;

endmodule

// ===== rtl/core/fpr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame packet reassembler checker
// Port-level checks on result buffering and flow control.
// ----------------------------------------------------------------------------
module fpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_write_address,
   input logic [7:0]  rsp_received_length
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_item_appears : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> rsp_valid)
      else $error("accepted item gave no result");

   a_ready_only_when_backed : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_write_address) && $stable(rsp_received_length)))
      else $error("stalled result changed");

endmodule

bind frame_packet_reassembler fpr_checker u_fpr_checker (.*);
